@@ design/lhss_pkg.sv @@
// Shared types and constants for the line hash shard selector.
package lhss_pkg;

  // Field and register widths
  localparam int HASH_W  = 32;
  localparam int SHARD_W = 11;
  localparam int INDEX_W = 10;
  localparam int LIMIT_W = 16;
  localparam int LEN_W   = 17;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 2;

  // Largest shard count that the divider serves
  localparam logic [SHARD_W-1:0] MAX_SHARDS = SHARD_W'(1024);

  // Byte that ends a line
  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

  // Register indexes of the configuration port
  localparam logic [CFG_W-1:0] CFG_HASH_SEED   = 2'd0;
  localparam logic [CFG_W-1:0] CFG_SHARD_COUNT = 2'd1;
  localparam logic [CFG_W-1:0] CFG_LINE_LIMIT  = 2'd2;

  // Reset values of the registers
  localparam logic [HASH_W-1:0]  SEED_RESET   = 32'd131;
  localparam logic [SHARD_W-1:0] SHARDS_RESET = 11'd100;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 16'd4094;

  // Operations of the iterative unit
  typedef enum logic {
    OP_MULADD,
    OP_MOD
  } op_t;

  // Request from the controller to the iterative unit
  typedef struct packed {
    logic                start;
    op_t                 op;
    logic [HASH_W-1:0]   opa;
    logic [HASH_W-1:0]   opb;
    logic [HASH_W-1:0]   addend;
    logic [SHARD_W-1:0]  divisor;
  } unit_req_t;

  // Response of the iterative unit
  typedef struct packed {
    logic                done;
    logic [HASH_W-1:0]   result;
  } unit_rsp_t;

endpackage

@@ design/line_hash_shard_selector.sv @@
// A text byte is accepted, runs the multiply steps and the add in the unit, and is written back.
// A newline ending a non-empty line is accepted, runs the modulo steps and loads the result
// register via S_PUSH; the empty-line newline and halted bytes finish when accepted.
// A new byte is taken only once the bit-serial shared adder unit has finished the last one.
// Reset (synchronous, rst high) clears hash, count, halt flag and output valid,
// and loads seed 131, shard count 100 and line limit 4094.
module line_hash_shard_selector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lhss_pkg::BYTE_W-1:0]     line_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lhss_pkg::INDEX_W-1:0]    shard_index,
  output logic [lhss_pkg::LEN_W-1:0]      written_length,
  output logic                            too_long,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lhss_pkg::CFG_W-1:0]      cfg_index,
  input  logic [lhss_pkg::HASH_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_MOD,
    S_PUSH
  } state_t;

  state_t                          state;
  logic [lhss_pkg::HASH_W-1:0]     hash_seed;
  logic [lhss_pkg::SHARD_W-1:0]    shard_count;
  logic [lhss_pkg::LIMIT_W-1:0]    line_limit;
  logic [lhss_pkg::HASH_W-1:0]     running_hash;
  logic [lhss_pkg::LIMIT_W-1:0]    char_count;
  logic                            halted;
  logic [lhss_pkg::INDEX_W-1:0]    res_shard;
  logic [lhss_pkg::LEN_W-1:0]      res_len;
  logic                            res_err;

  logic                            accept;
  logic                            is_newline;
  logic [lhss_pkg::SHARD_W-1:0]    eff_shards;
  lhss_pkg::unit_req_t             req;
  lhss_pkg::unit_rsp_t             rsp;

  assign in_ready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = in_valid && in_ready;
  assign is_newline = (line_byte == lhss_pkg::NEWLINE_BYTE);

  // Clamp the divisor to the range the divider serves
  always_comb begin
    if (shard_count == '0) begin
      eff_shards = lhss_pkg::SHARD_W'(1);
    end else if (shard_count > lhss_pkg::MAX_SHARDS) begin
      eff_shards = lhss_pkg::MAX_SHARDS;
    end else begin
      eff_shards = shard_count;
    end
  end

  // Launch the unit for a hashed byte or a finished line
  always_comb begin
    req.start   = accept && !halted &&
                  ((is_newline && char_count != '0) ||
                   (!is_newline && char_count < line_limit));
    req.op      = is_newline ? lhss_pkg::OP_MOD : lhss_pkg::OP_MULADD;
    req.opa     = running_hash;
    req.opb     = hash_seed;
    req.addend  = {{(lhss_pkg::HASH_W - lhss_pkg::BYTE_W){line_byte[lhss_pkg::BYTE_W-1]}},
                   line_byte};
    req.divisor = eff_shards;
  end

  lhss_iter_unit u_iter (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Control, line state, registers and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      hash_seed    <= lhss_pkg::SEED_RESET;
      shard_count  <= lhss_pkg::SHARDS_RESET;
      line_limit   <= lhss_pkg::LIMIT_RESET;
      running_hash <= '0;
      char_count   <= '0;
      halted       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // Take configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lhss_pkg::CFG_HASH_SEED:   hash_seed   <= cfg_data;
          lhss_pkg::CFG_SHARD_COUNT: shard_count <= cfg_data[lhss_pkg::SHARD_W-1:0];
          lhss_pkg::CFG_LINE_LIMIT:  line_limit  <= cfg_data[lhss_pkg::LIMIT_W-1:0];
          default: begin
          end
        endcase
      end

      // Drop the output item once taken, unless a new one replaces it
      if (out_valid && out_ready && state != S_PUSH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && !halted) begin
            if (is_newline) begin
              running_hash <= '0;
              char_count   <= '0;
              if (char_count != '0) begin
                res_len <= {1'b0, char_count} + lhss_pkg::LEN_W'(1);
                res_err <= 1'b0;
                state   <= S_MOD;
              end
            end else if (char_count >= line_limit) begin
              halted       <= 1'b1;
              running_hash <= '0;
              char_count   <= '0;
              res_shard    <= '0;
              res_len      <= '0;
              res_err      <= 1'b1;
              state        <= S_PUSH;
            end else begin
              char_count <= char_count + 1'b1;
              state      <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (rsp.done) begin
            running_hash <= rsp.result;
            state        <= S_IDLE;
          end
        end
        S_MOD: begin
          if (rsp.done) begin
            res_shard <= rsp.result[lhss_pkg::INDEX_W-1:0];
            state     <= S_PUSH;
          end
        end
        S_PUSH: begin
          // Hold the result until the output register is free
          if (!out_valid || out_ready) begin
            shard_index    <= res_shard;
            written_length <= res_len;
            too_long       <= res_err;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The halt flag is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halt flag cleared without reset");

  // An error item carries zero shard and zero length
  a_err_payload: assert property (@(posedge clk) disable iff (rst)
      (out_valid && too_long) |-> (shard_index == '0 && written_length == '0))
    else $error("error item with nonzero payload");

  // A line item has a shard below the divisor and a length of at least two
  a_line_payload: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !too_long) |->
      ({1'b0, shard_index} < eff_shards && written_length >= lhss_pkg::LEN_W'(2)))
    else $error("line item out of range");

  // The unit finishes only while the controller waits for it
  a_done_expected: assert property (@(posedge clk) disable iff (rst)
      rsp.done |-> (state == S_HASH || state == S_MOD))
    else $error("unexpected completion from iterative unit");

endmodule

@@ design/lhss_iter_unit.sv @@
// Iterative unit: shift-add multiply-accumulate and restoring modulo on one shared adder.
module lhss_iter_unit (
  input  logic               clk,
  input  logic               rst,
  input  lhss_pkg::unit_req_t req,
  output lhss_pkg::unit_rsp_t rsp
);

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_ADD,
    U_MOD
  } ustate_t;

  localparam int CNT_W = $clog2(lhss_pkg::HASH_W);
  localparam int PAD_W = lhss_pkg::HASH_W - lhss_pkg::INDEX_W - 1;
  localparam int DPAD_W = lhss_pkg::HASH_W - lhss_pkg::SHARD_W;

  ustate_t                          state;
  logic [CNT_W-1:0]                 count;
  logic [lhss_pkg::HASH_W-1:0]      acc;
  logic [lhss_pkg::HASH_W-1:0]      mult;
  logic [lhss_pkg::HASH_W-1:0]      opa_r;
  logic [lhss_pkg::HASH_W-1:0]      addend_r;
  logic [lhss_pkg::SHARD_W-1:0]     div_r;
  logic [lhss_pkg::INDEX_W-1:0]     rem;
  logic                             done;
  logic                             last_mod;

  logic [lhss_pkg::HASH_W-1:0]      add_x;
  logic [lhss_pkg::HASH_W-1:0]      add_y;
  logic                             add_sub;
  logic [lhss_pkg::HASH_W:0]        sum;

  // Select the operands of the shared adder for the current step
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state)
      U_MUL: begin
        add_x = {acc[lhss_pkg::HASH_W-2:0], 1'b0};
        add_y = mult[lhss_pkg::HASH_W-1] ? opa_r : '0;
      end
      U_ADD: begin
        add_x = acc;
        add_y = addend_r;
      end
      U_MOD: begin
        add_x   = {{PAD_W{1'b0}}, rem, acc[lhss_pkg::HASH_W-1]};
        add_y   = {{DPAD_W{1'b0}}, div_r};
        add_sub = 1'b1;
      end
      default: begin
        add_x = '0;
      end
    endcase
  end

  // Shared adder; carry out set means no borrow on subtract
  assign sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
             + {{lhss_pkg::HASH_W{1'b0}}, add_sub};

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= U_IDLE;
      count    <= '0;
      done     <= 1'b0;
      last_mod <= 1'b0;
    end else begin
      unique case (state)
        U_IDLE: begin
          done <= 1'b0;
          if (req.start) begin
            count <= CNT_W'(lhss_pkg::HASH_W - 1);
            opa_r    <= req.opa;
            addend_r <= req.addend;
            div_r    <= req.divisor;
            rem      <= '0;
            if (req.op == lhss_pkg::OP_MOD) begin
              acc      <= req.opa;
              last_mod <= 1'b1;
              state    <= U_MOD;
            end else begin
              acc      <= '0;
              mult     <= req.opb;
              last_mod <= 1'b0;
              state    <= U_MUL;
            end
          end
        end
        U_MUL: begin
          done <= 1'b0;
          acc  <= sum[lhss_pkg::HASH_W-1:0];
          mult <= {mult[lhss_pkg::HASH_W-2:0], 1'b0};
          if (count == '0) begin
            state <= U_ADD;
          end else begin
            count <= count - 1'b1;
          end
        end
        U_ADD: begin
          acc   <= sum[lhss_pkg::HASH_W-1:0];
          done  <= 1'b1;
          state <= U_IDLE;
        end
        U_MOD: begin
          acc <= {acc[lhss_pkg::HASH_W-2:0], 1'b0};
          rem <= sum[lhss_pkg::HASH_W] ? sum[lhss_pkg::INDEX_W-1:0]
                                       : add_x[lhss_pkg::INDEX_W-1:0];
          if (count == '0) begin
            done  <= 1'b1;
            state <= U_IDLE;
          end else begin
            done  <= 1'b0;
            count <= count - 1'b1;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= U_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = last_mod ? {{(lhss_pkg::HASH_W - lhss_pkg::INDEX_W){1'b0}}, rem} : acc;

endmodule
